// ===== rtl/core/toy_vm_register_execute_unit_defines.svh =====
// Assertion macros for the toy VM execute unit top level.
`ifndef TOY_VM_REGISTER_EXECUTE_UNIT_DEFINES_SVH
`define TOY_VM_REGISTER_EXECUTE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define TVRX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define TVRX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tvrx_pkg.sv =====
// Types and constants shared by the toy VM execute unit modules.
`timescale 1ns / 1ps

package tvrx_pkg;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 104;

   localparam logic [3:0] OP_CMP   = 4'd0;
   localparam logic [3:0] OP_CMPR  = 4'd1;
   localparam logic [3:0] OP_NOP   = 4'd2;
   localparam logic [3:0] OP_JMP   = 4'd3;
   localparam logic [3:0] OP_INC   = 4'd4;
   localparam logic [3:0] OP_DEC   = 4'd5;
   localparam logic [3:0] OP_ADDR  = 4'd6;
   localparam logic [3:0] OP_SUBR  = 4'd7;
   localparam logic [3:0] OP_ADD   = 4'd8;
   localparam logic [3:0] OP_SUB   = 4'd9;
   localparam logic [3:0] OP_LOADR = 4'd10;
   localparam logic [3:0] OP_LOADI = 4'd11;

   localparam logic [2:0] IDX_SP = 3'd4;
   localparam logic [2:0] IDX_PC = 3'd5;

   // Decoded request as it waits between front and back.
   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  dst_idx;
      logic [1:0]  src_idx;
      logic        dst_gp;
      logic        dst_sp;
      logic        dst_pc;
      logic        src_gp;
      logic        src_sp;
      logic        src_pc;
      logic [31:0] imm;
      logic [31:0] imm8;
   } dec_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      dec_type dec;
   } head_type;

endpackage

// ===== rtl/core/toy_vm_register_execute_unit.sv =====
// Top level of the toy VM register execute unit.
`timescale 1ns / 1ps
// Usage:
//   Send one instruction per request on the req_ stream; each request yields
//   exactly one response on the rsp_ stream, in order.
//   The front end decodes a request and pushes it into a short queue; the back
//   end pops the queue head, executes it against the four general registers,
//   stack pointer, program counter and sticky flags, and registers the response.
//   Path: an accepted request is registered in the queue, popped from its head
//   when the response register is free or being emptied, and executed into
//   the response register, which drives rsp_tvalid.
//   Throughput: one request per cycle while rsp_tready stays high; each instruction
//   completes its state update as it is popped, so the next one follows directly.
//   Stall: when rsp_tready is low the response register holds, the back end
//   stops popping, and the queue fills; req_tready drops only when the queue
//   is full (QUEUE_DEPTH requests).
//   Reset: clears all registers, flags, the queue and the response valid.

`include "toy_vm_register_execute_unit_defines.svh"

module toy_vm_register_execute_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: req_type[3:0], reg_dest[6:4], reg_src[9:7], immediate[41:10], zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tvrx_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: compare_diff[31:0], written_value[63:32], wrote_register[64],
   //   pc_value[96:65], zero_flag_out[97], carry_flag_out[98],
   //   overflow_flag_out[99], bad_register[100], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tvrx_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic               q_full;
   logic               push;
   logic               pop;
   tvrx_pkg::dec_type  push_dec;
   tvrx_pkg::head_type head;

   // Response fields watched by the checks below
   logic               rsp_wrote;
   logic               rsp_bad;
   logic [31:0]        rsp_wval;

   assign rsp_wrote = rsp_tdata[64];
   assign rsp_bad   = rsp_tdata[100];
   assign rsp_wval  = rsp_tdata[63:32];

   // Decode and admit requests
   tvrx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_dec   (push_dec)
   );

   // Buffer decoded requests so either side can stall alone
   tvrx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_dec (push_dec),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   // Execute and hold the response
   tvrx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `TVRX_ASSERT_NEXT(a_push_lands, push, head.valid, "accepted request not queued")
   `TVRX_ASSERT_NEXT(a_head_drains, pop, rsp_tvalid, "popped request not in response register")
   `TVRX_ASSERT_NOW(a_wval_zero, rsp_tvalid && !rsp_wrote, rsp_wval == '0, "stray written value")
   `TVRX_ASSERT_NOW(a_bad_nowrite, rsp_tvalid && rsp_bad, !rsp_wrote, "bad index with write")

endmodule

// ===== rtl/core/tvrx_front.sv =====
// Front end: accepts requests and decodes them for the queue.
`timescale 1ns / 1ps

module tvrx_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tvrx_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               q_full,
   output logic                               push,
   output tvrx_pkg::dec_type                  push_dec
);

   logic [2:0] dst;
   logic [2:0] src;

   assign dst = req_tdata[6:4];
   assign src = req_tdata[9:7];

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_dec.op      = req_tdata[3:0];
      push_dec.dst_idx = dst[1:0];
      push_dec.src_idx = src[1:0];
      push_dec.dst_gp  = !dst[2];
      push_dec.dst_sp  = (dst == tvrx_pkg::IDX_SP);
      push_dec.dst_pc  = (dst == tvrx_pkg::IDX_PC);
      push_dec.src_gp  = !src[2];
      push_dec.src_sp  = (src == tvrx_pkg::IDX_SP);
      push_dec.src_pc  = (src == tvrx_pkg::IDX_PC);
      push_dec.imm     = req_tdata[41:10];
      push_dec.imm8    = {24'd0, req_tdata[17:10]};
   end

endmodule

// ===== rtl/core/tvrx_queue.sv =====
// Short queue of decoded requests between front and back end.
`timescale 1ns / 1ps

module tvrx_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tvrx_pkg::dec_type   push_dec,
   input  logic                pop,
   output logic                full,
   output tvrx_pkg::head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tvrx_pkg::dec_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.dec   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_dec;
      end
   end

endmodule

// ===== rtl/core/tvrx_back.sv =====
// Back end: executes decoded requests against the VM state, registers the response.
`timescale 1ns / 1ps

module tvrx_back (
   input  logic                               clock,
   input  logic                               reset,
   input  tvrx_pkg::head_type                 head,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tvrx_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [31:0] gp_ff [4];
   logic [31:0] gp_in [4];
   logic [31:0] sp_ff, sp_in;
   logic [31:0] pc_ff, pc_in;
   logic        zf_ff, zf_in;
   logic        cf_ff, cf_in;
   logic        of_ff, of_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [tvrx_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   tvrx_pkg::dec_type dec;
   logic [31:0] gd, gs, ra, rb, cmp_opnd, cmpr_d;
   logic [31:0] diff, wval;
   logic        wrote, bad;

   assign dec = head.dec;
   assign pop = head.valid && (!rsp_tvalid_ff || rsp_tready);

   // Operand reads
   always_comb begin
      gd       = dec.dst_gp ? gp_ff[dec.dst_idx] : '0;
      gs       = dec.src_gp ? gp_ff[dec.src_idx] : '0;
      ra       = dec.dst_gp ? gd : dec.dst_sp ? sp_ff : dec.dst_pc ? pc_ff : '0;
      rb       = dec.src_gp ? gs : dec.src_sp ? sp_ff : dec.src_pc ? pc_ff : '0;
      cmp_opnd = dec.src_gp ? gs : dec.src_sp ? sp_ff : '0;
      cmpr_d   = gs - gd;
   end

   always_comb begin
      gp_in = gp_ff;
      sp_in = sp_ff;
      pc_in = pc_ff;
      zf_in = zf_ff;
      cf_in = cf_ff;
      of_in = of_ff;
      diff  = '0;
      wval  = '0;
      wrote = 1'b0;
      bad   = 1'b0;
      case (dec.op)
         tvrx_pkg::OP_CMP: begin
            diff = dec.imm - cmp_opnd;
         end
         tvrx_pkg::OP_CMPR: begin
            if (cmpr_d == '0) zf_in = 1'b1;
            if (cmpr_d[31])   cf_in = 1'b1;
            if (|cmpr_d[31:8]) of_in = 1'b1;
         end
         tvrx_pkg::OP_NOP: begin
            pc_in = pc_ff + 32'd1;
         end
         tvrx_pkg::OP_JMP: begin
            pc_in = dec.imm8;
         end
         tvrx_pkg::OP_INC, tvrx_pkg::OP_DEC, tvrx_pkg::OP_ADD, tvrx_pkg::OP_SUB: begin
            if (dec.dst_gp) begin
               case (dec.op)
                  tvrx_pkg::OP_INC: wval = gd + 32'd1;
                  tvrx_pkg::OP_DEC: wval = gd - 32'd1;
                  tvrx_pkg::OP_ADD: wval = gd + dec.imm8;
                  default:          wval = gd - dec.imm8;
               endcase
               gp_in[dec.dst_idx] = wval;
               wrote = 1'b1;
            end
         end
         tvrx_pkg::OP_ADDR, tvrx_pkg::OP_SUBR: begin
            if (dec.dst_gp || dec.dst_sp) begin
               wval = (dec.op == tvrx_pkg::OP_ADDR) ? ra + rb : ra - rb;
               if (dec.dst_gp) gp_in[dec.dst_idx] = wval;
               else            sp_in = wval;
               wrote = 1'b1;
            end
         end
         tvrx_pkg::OP_LOADR: begin
            if (dec.dst_gp) begin
               wval = rb;
               gp_in[dec.dst_idx] = wval;
               wrote = 1'b1;
            end
         end
         tvrx_pkg::OP_LOADI: begin
            if (dec.dst_gp || dec.dst_sp || dec.dst_pc) begin
               wval  = dec.imm8;
               wrote = 1'b1;
               if (dec.dst_gp)      gp_in[dec.dst_idx] = dec.imm8;
               else if (dec.dst_sp) sp_in = dec.imm8;
               else                 pc_in = dec.imm8;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in   = {3'd0, bad, of_in, cf_in, zf_in, pc_in, wrote, wval, diff};
      rsp_tvalid_in = pop ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff         <= '{default: '0};
         sp_ff         <= '0;
         pc_ff         <= '0;
         zf_ff         <= 1'b0;
         cf_ff         <= 1'b0;
         of_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (pop) begin
            gp_ff <= gp_in;
            sp_ff <= sp_in;
            pc_ff <= pc_in;
            zf_ff <= zf_in;
            cf_ff <= cf_in;
            of_ff <= of_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/sv/tb_toy_vm_register_execute_unit.sv =====
// Self-checking testbench for the toy VM register execute unit.
`timescale 1ns / 1ps

module tb_toy_vm_register_execute_unit;

   // Register indexes and request codes that the package leaves unnamed.
   localparam logic [2:0] IDX_R0     = 3'd0;
   localparam logic [2:0] IDX_R1     = 3'd1;
   localparam logic [2:0] IDX_R2     = 3'd2;
   localparam logic [2:0] IDX_R3     = 3'd3;
   localparam logic [2:0] IDX_BAD_LO = 3'd6;
   localparam logic [2:0] IDX_BAD_HI = 3'd7;
   localparam logic [3:0] OP_SPARE_LO = 4'd12;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   localparam logic [31:0] CMPR_OVF_LIMIT = 32'd255;
   localparam int RANDOM_INSTRS  = 1850;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   // One instruction as packed on req_tdata, lowest field last.
   typedef struct packed {
      logic [31:0] imm;
      logic [2:0]  src;
      logic [2:0]  dst;
      logic [3:0]  op;
   } vm_instr_type;

   // One response as packed on rsp_tdata[100:0], lowest field last.
   typedef struct packed {
      logic        bad_register;
      logic        overflow_flag_out;
      logic        carry_flag_out;
      logic        zero_flag_out;
      logic [31:0] pc_value;
      logic        wrote_register;
      logic [31:0] written_value;
      logic [31:0] compare_diff;
   } vm_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [tvrx_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [tvrx_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   toy_vm_register_execute_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Architectural state as the predictor sees it.
   logic [31:0] gp_regs [4];
   logic [31:0] sp_reg;
   logic [31:0] pc_reg;
   logic        zero_flag;
   logic        carry_flag;
   logic        overflow_flag;

   vm_instr_type  queued_instrs [$];
   vm_result_type predicted_rsps [$];
   int            total_instrs;
   int            reqs_accepted;
   int            mismatch_count;
   int            stalled_cycles;
   bit            req_taken;

   // Read a register by index; indexes a given operation does not accept read 0.
   function automatic logic [31:0] read_reg(logic [2:0] idx, bit with_sp, bit with_pc);
      if (idx <= IDX_R3)
         return gp_regs[idx[1:0]];
      if (idx == tvrx_pkg::IDX_SP && with_sp)
         return sp_reg;
      if (idx == tvrx_pkg::IDX_PC && with_pc)
         return pc_reg;
      return 32'd0;
   endfunction

   // Execute one instruction against the predicted state; return its response.
   function automatic vm_result_type execute_instr(vm_instr_type ins);
      vm_result_type res;
      logic [31:0]   imm8;
      logic [31:0]   diff;
      logic [31:0]   val;
      res  = '0;
      imm8 = {24'd0, ins.imm[7:0]};
      case (ins.op)
         tvrx_pkg::OP_CMP: begin
            res.compare_diff = ins.imm - read_reg(ins.src, 1'b1, 1'b0);
         end
         tvrx_pkg::OP_CMPR: begin
            // Flags only ever get set here; reset is the sole way back.
            diff = read_reg(ins.src, 1'b0, 1'b0) - read_reg(ins.dst, 1'b0, 1'b0);
            if (diff == 32'd0)
               zero_flag = 1'b1;
            if (diff[31]) begin
               carry_flag    = 1'b1;
               overflow_flag = 1'b1;
            end else if (diff > CMPR_OVF_LIMIT) begin
               overflow_flag = 1'b1;
            end
         end
         tvrx_pkg::OP_NOP: pc_reg = pc_reg + 32'd1;
         tvrx_pkg::OP_JMP: pc_reg = imm8;
         tvrx_pkg::OP_INC, tvrx_pkg::OP_DEC, tvrx_pkg::OP_ADD, tvrx_pkg::OP_SUB: begin
            if (ins.dst <= IDX_R3) begin
               val = gp_regs[ins.dst[1:0]];
               case (ins.op)
                  tvrx_pkg::OP_INC: val = val + 32'd1;
                  tvrx_pkg::OP_DEC: val = val - 32'd1;
                  tvrx_pkg::OP_ADD: val = val + imm8;
                  default:          val = val - imm8;
               endcase
               gp_regs[ins.dst[1:0]] = val;
               res.written_value  = val;
               res.wrote_register = 1'b1;
            end
         end
         tvrx_pkg::OP_ADDR, tvrx_pkg::OP_SUBR: begin
            if (ins.dst <= IDX_R3 || ins.dst == tvrx_pkg::IDX_SP) begin
               val = read_reg(ins.dst, 1'b1, 1'b1);
               if (ins.op == tvrx_pkg::OP_ADDR)
                  val = val + read_reg(ins.src, 1'b1, 1'b1);
               else
                  val = val - read_reg(ins.src, 1'b1, 1'b1);
               if (ins.dst == tvrx_pkg::IDX_SP)
                  sp_reg = val;
               else
                  gp_regs[ins.dst[1:0]] = val;
               res.written_value  = val;
               res.wrote_register = 1'b1;
            end
         end
         tvrx_pkg::OP_LOADR: begin
            if (ins.dst <= IDX_R3) begin
               val = read_reg(ins.src, 1'b1, 1'b1);
               gp_regs[ins.dst[1:0]] = val;
               res.written_value  = val;
               res.wrote_register = 1'b1;
            end
         end
         tvrx_pkg::OP_LOADI: begin
            if (ins.dst <= IDX_R3)
               gp_regs[ins.dst[1:0]] = imm8;
            else if (ins.dst == tvrx_pkg::IDX_SP)
               sp_reg = imm8;
            else if (ins.dst == tvrx_pkg::IDX_PC)
               pc_reg = imm8;
            if (ins.dst >= IDX_BAD_LO) begin
               res.bad_register = 1'b1;
            end else begin
               res.written_value  = imm8;
               res.wrote_register = 1'b1;
            end
         end
         default: ;
      endcase
      res.pc_value          = pc_reg;
      res.zero_flag_out     = zero_flag;
      res.carry_flag_out    = carry_flag;
      res.overflow_flag_out = overflow_flag;
      return res;
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what,
               got, exp);
      mismatch_count++;
   endtask

   task automatic queue_instr(logic [3:0] op, logic [2:0] dst, logic [2:0] src,
                              logic [31:0] imm);
      vm_instr_type ins;
      ins.op  = op;
      ins.dst = dst;
      ins.src = src;
      ins.imm = imm;
      queued_instrs.push_back(ins);
   endtask

   // Mostly valid indexes, now and then one that no operation accepts.
   function automatic logic [2:0] pick_index();
      if ($urandom_range(0, 99) < 88)
         return 3'($urandom_range(IDX_R0, tvrx_pkg::IDX_PC));
      return 3'($urandom_range(IDX_BAD_LO, IDX_BAD_HI));
   endfunction

   // Idle percentages per phase: sender-light/receiver-heavy, swapped, none.
   function automatic int sender_idle_pct();
      if (reqs_accepted < total_instrs / 3)
         return 12;
      if (reqs_accepted < 2 * total_instrs / 3)
         return 45;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (reqs_accepted < total_instrs / 3)
         return 45;
      if (reqs_accepted < 2 * total_instrs / 3)
         return 12;
      return 0;
   endfunction

   // Driver: change inputs on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // Hold the request until it is taken.
      end else if (queued_instrs.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct()) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {{(tvrx_pkg::REQ_TDATA_W - $bits(vm_instr_type)){1'b0}},
                        queued_instrs[0]};
      end else begin
         req_tvalid <= 1'b0;
      end
      req_taken = 1'b0;
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
   end

   // Monitor: sample handshakes on the rising edge, predict and check.
   always @(posedge clock) begin
      vm_result_type got;
      vm_result_type exp;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted_rsps.push_back(execute_instr(queued_instrs.pop_front()));
            reqs_accepted++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(vm_result_type)-1:0];
            if (predicted_rsps.size() == 0) begin
               report_mismatch("unexpected response", got.pc_value, 32'd0);
            end else begin
               exp = predicted_rsps.pop_front();
               if (got.compare_diff !== exp.compare_diff)
                  report_mismatch("compare_diff", got.compare_diff, exp.compare_diff);
               if (got.written_value !== exp.written_value)
                  report_mismatch("written_value", got.written_value, exp.written_value);
               if (got.wrote_register !== exp.wrote_register)
                  report_mismatch("wrote_register", 32'(got.wrote_register),
                                  32'(exp.wrote_register));
               if (got.pc_value !== exp.pc_value)
                  report_mismatch("pc_value", got.pc_value, exp.pc_value);
               if (got.zero_flag_out !== exp.zero_flag_out)
                  report_mismatch("zero_flag_out", 32'(got.zero_flag_out),
                                  32'(exp.zero_flag_out));
               if (got.carry_flag_out !== exp.carry_flag_out)
                  report_mismatch("carry_flag_out", 32'(got.carry_flag_out),
                                  32'(exp.carry_flag_out));
               if (got.overflow_flag_out !== exp.overflow_flag_out)
                  report_mismatch("overflow_flag_out", 32'(got.overflow_flag_out),
                                  32'(exp.overflow_flag_out));
               if (got.bad_register !== exp.bad_register)
                  report_mismatch("bad_register", 32'(got.bad_register),
                                  32'(exp.bad_register));
            end
         end
         // Watchdog: any handshake restarts the count.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("toy_vm_register_execute_unit test failed");
            $finish;
         end
      end
   end

   initial begin
      vm_instr_type ins;
      logic [3:0]   op;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b1;
      req_taken      = 1'b0;
      reqs_accepted  = 0;
      mismatch_count = 0;
      stalled_cycles = 0;
      sp_reg         = '0;
      pc_reg         = '0;
      zero_flag      = 1'b0;
      carry_flag     = 1'b0;
      overflow_flag  = 1'b0;
      foreach (gp_regs[i])
         gp_regs[i] = '0;

      // Directed part. Upper immediate bits must be dropped where only the low
      // byte counts.
      queue_instr(tvrx_pkg::OP_NOP,   IDX_R0, IDX_R0, 32'd0);
      queue_instr(tvrx_pkg::OP_LOADI, IDX_R1, IDX_R0, 32'hFFFF_FFC8);  // r1 = 200
      queue_instr(tvrx_pkg::OP_ADD,   IDX_R1, IDX_R0, 32'h7FFF_FFC8);  // r1 = 400
      queue_instr(tvrx_pkg::OP_LOADI, IDX_R0, IDX_R0, 32'h8000_0064);  // r0 = 100
      // Walk the flags one at a time: none, overflow, zero, then carry.
      queue_instr(tvrx_pkg::OP_CMPR,  IDX_R2, IDX_R0, 32'd0);          // 100 - 0
      queue_instr(tvrx_pkg::OP_CMPR,  IDX_R0, IDX_R1, 32'd0);          // 400 - 100
      queue_instr(tvrx_pkg::OP_CMPR,  IDX_R3, IDX_R2, 32'd0);          // 0 - 0
      queue_instr(tvrx_pkg::OP_CMPR,  IDX_R1, IDX_R0, 32'd0);          // 100 - 400
      queue_instr(tvrx_pkg::OP_CMPR,  tvrx_pkg::IDX_PC, IDX_BAD_HI, 32'd0);  // both 0
      queue_instr(tvrx_pkg::OP_CMP,   IDX_R0, IDX_R1, 32'h8000_0000);
      queue_instr(tvrx_pkg::OP_CMP,   IDX_R0, tvrx_pkg::IDX_SP, 32'h7FFF_FFFF);
      // pc source reads as 0
      queue_instr(tvrx_pkg::OP_CMP,   IDX_R0, tvrx_pkg::IDX_PC, 32'hFFFF_FFFF);
      queue_instr(tvrx_pkg::OP_JMP,   IDX_R0, IDX_R0, 32'hFFFF_FFFF);  // pc = 255
      queue_instr(tvrx_pkg::OP_DEC,   IDX_R2, IDX_R0, 32'd0);          // wrap below zero
      queue_instr(tvrx_pkg::OP_INC,   IDX_R2, IDX_R0, 32'd0);          // wrap back
      // ignored destination
      queue_instr(tvrx_pkg::OP_INC,   tvrx_pkg::IDX_SP, IDX_R0, 32'd0);
      queue_instr(tvrx_pkg::OP_SUB,   IDX_R3, IDX_R0, 32'h0000_00FF);
      queue_instr(tvrx_pkg::OP_ADDR,  tvrx_pkg::IDX_SP, IDX_R1, 32'd0);
      queue_instr(tvrx_pkg::OP_SUBR,  IDX_R0, tvrx_pkg::IDX_PC, 32'd0);
      queue_instr(tvrx_pkg::OP_ADDR,  IDX_R2, IDX_BAD_LO, 32'd0);
      // ignored destination
      queue_instr(tvrx_pkg::OP_SUBR,  tvrx_pkg::IDX_PC, IDX_R1, 32'd0);
      queue_instr(tvrx_pkg::OP_LOADR, IDX_R3, tvrx_pkg::IDX_SP, 32'd0);
      // ignored destination
      queue_instr(tvrx_pkg::OP_LOADR, tvrx_pkg::IDX_SP, IDX_R0, 32'd0);
      queue_instr(tvrx_pkg::OP_LOADI, tvrx_pkg::IDX_PC, IDX_R0, 32'h5A5A_5A12);
      queue_instr(tvrx_pkg::OP_LOADI, IDX_BAD_LO, IDX_R0, 32'd7);      // flags a bad register
      queue_instr(tvrx_pkg::OP_LOADI, IDX_BAD_HI, IDX_R0, 32'd9);
      queue_instr(OP_SPARE_LO, IDX_R1, IDX_R2, 32'hFFFF_FFFF);
      queue_instr(OP_SPARE_HI, IDX_BAD_HI, IDX_BAD_HI, 32'd0);

      // Random part: mostly defined operations, some spare codes.
      repeat (RANDOM_INSTRS) begin
         if ($urandom_range(0, 99) < 92)
            op = 4'($urandom_range(tvrx_pkg::OP_CMP, tvrx_pkg::OP_LOADI));
         else
            op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         ins.op  = op;
         ins.dst = pick_index();
         ins.src = pick_index();
         case ($urandom_range(0, 7))
            0, 1: ins.imm = 32'($urandom_range(0, 300));
            2: begin
               case ($urandom_range(0, 3))
                  0:       ins.imm = 32'h8000_0000;
                  1:       ins.imm = 32'h7FFF_FFFF;
                  2:       ins.imm = 32'hFFFF_FFFF;
                  default: ins.imm = 32'h0000_0000;
               endcase
            end
            default: ins.imm = $urandom;
         endcase
         queued_instrs.push_back(ins);
      end
      total_instrs = queued_instrs.size();

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Drain: wait until every request is taken and answered.
      while (queued_instrs.size() != 0 || predicted_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("toy_vm_register_execute_unit test passed");
      else
         $display("toy_vm_register_execute_unit test failed");
      $finish;
   end

endmodule

// ===== toy_vm_register_execute_unit.f =====
+incdir+rtl/core
rtl/core/tvrx_pkg.sv
rtl/core/tvrx_front.sv
rtl/core/tvrx_queue.sv
rtl/core/tvrx_back.sv
rtl/core/toy_vm_register_execute_unit.sv
tb/sv/tb_toy_vm_register_execute_unit.sv
